@@ rtl/core/plsa_pkg.sv @@
`default_nettype none

package plsa_pkg;

	localparam int CFG_W  = 13;
	localparam int MARG_W = 12;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	// Signed width that holds every position, bound and bound plus margin.
	localparam int GEO_W  = 17;
	localparam int SUM_W  = 32;
	localparam int CNT_W  = 25;
	localparam int WGT_W  = 14;

	localparam int WEIGHT_B = 722;
	localparam int WEIGHT_G = 7152;
	localparam int WEIGHT_R = 2126;
	localparam int LUM_SCALE = 255;
	localparam int LUM_DIV   = 10000;
	localparam int LUM_HALF  = 5000;

	// The scaled luminance numerator, once its fraction bits are dropped, stays below 2^22.
	// A ceiling reciprocal of 2^36 / 10000 then gives the exact floored quotient.
	localparam int LUM_M_W      = 22;
	localparam int RECIP_W      = 23;
	localparam int LUM_P_W      = LUM_M_W + RECIP_W;
	localparam int LUM_RECIP_SH = 36;
	localparam logic [RECIP_W-1:0] LUM_RECIP =
		RECIP_W'(((64'd1 << LUM_RECIP_SH) + 64'(LUM_DIV) - 64'd1) / 64'(LUM_DIV));

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_BOX_LEFT     = 3'd2;
	localparam logic [2:0] REG_BOX_TOP      = 3'd3;
	localparam logic [2:0] REG_BOX_RIGHT    = 3'd4;
	localparam logic [2:0] REG_BOX_BOTTOM   = 3'd5;
	localparam logic [2:0] REG_MARGIN_COLS  = 3'd6;
	localparam logic [2:0] REG_MARGIN_ROWS  = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_NUM,
		ST_LDIV,
		ST_ACC,
		ST_AVG,
		ST_ADIV,
		ST_DONE
	} state_t;

	// Linear light of one sRGB code as a fraction with l fraction bits.
	// Evaluated only at elaboration to fill the lane tables.
	function automatic logic [31:0] lin_value(input int unsigned c, input int unsigned l);
		longint unsigned one;
		longint unsigned lim;
		longint unsigned v;
		longint unsigned t;
		longint unsigned t2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned a;
		longint unsigned x;
		int k;
		one = 64'd1 << 30;
		lim = (64'd1 << l) - 64'd1;
		if (c <= 10) begin
			v = (longint'(c) * 100 * (64'd1 << l) + 164730) / 329460;
		end else begin
			t = (longint'(1000 * c + 14025) * one + 134512) / 269025;
			if (t > one) begin
				t = one;
			end
			t2 = (t * t + (one >> 1)) >> 30;
			lo = 0;
			hi = one;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				a = mid;
				for (k = 0; k < 4; k++) begin
					a = (a * mid) >> 30;
				end
				if (a <= t2) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
			x = (t2 * lo) >> 30;
			v = (x + (64'd1 << (29 - l))) >> (30 - l);
		end
		if (v > lim) begin
			v = lim;
		end
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/pixel_luminance_surround_average.sv @@
// Channel   Handshake               Payload
// pixel in  in_valid / in_ready     blue, green, red, start_of_frame
// result    out_valid / out_ready   luminance, average_valid, surround_average, region_empty
// config    psel, penable, pwrite   paddr, pwdata, prdata, pready
//
// Each pixel passes in turn through accept, lane sum, scale, reciprocal multiply, accumulate, load.
// The last pixel of a frame also runs the 32-step average divider, or skips it
// when its region is empty.
// Reset clears position, accumulators and control state; registers take their defaults.
// A finished result waits in the output register; a stalled sink holds the next pixel at its end.
`default_nettype none

module pixel_luminance_surround_average #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int LIN_FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [7:0]                   blue,
	input  wire logic [7:0]                   green,
	input  wire logic [7:0]                   red,
	input  wire logic                         start_of_frame,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [7:0]                   luminance,
	output logic                              average_valid,
	output logic      [7:0]                   surround_average,
	output logic                              region_empty,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [plsa_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [plsa_pkg::DATA_W-1:0]  pwdata,
	output logic      [plsa_pkg::DATA_W-1:0]  prdata,
	output logic                              pready
);

	localparam int L = LIN_FRAC_BITS;
	localparam int PROD_W = L + 14;
	localparam int NUM_W = L + 22;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int GW = plsa_pkg::GEO_W;
	localparam int CW = plsa_pkg::CFG_W;
	localparam int MW = plsa_pkg::MARG_W;

	plsa_pkg::state_t state_q, state_d;

	logic [CW-1:0] fw_q, fh_q, bl_q, bt_q, br_q, bb_q;
	logic [MW-1:0] mc_q, mr_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [plsa_pkg::SUM_W-1:0] sum_q;
	logic [plsa_pkg::CNT_W-1:0] cnt_q;
	logic region_q, last_q;
	logic [PROD_W-1:0] s_q;
	logic [plsa_pkg::LUM_M_W-1:0] lum_m_q;
	logic [7:0] lum_q, avg_q;
	logic out_valid_q;

	logic accept, cfg_wr, avg_start, out_load;
	logic [PROD_W-1:0] prod_b, prod_g, prod_r;
	logic [NUM_W-1:0] lum_num;
	logic [plsa_pkg::LUM_P_W-1:0] lum_prod;
	logic avg_done;
	logic [8:0] lum_quo;
	logic [plsa_pkg::SUM_W-1:0] avg_quo;

	logic signed [GW-1:0] wd, ht, x, y, xmin, xmax, ymin, ymax;
	logic in_box, in_region, is_last, col_wrap, row_wrap;

	assign accept = in_valid && in_ready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	plsa_lane #(.LIN_FRAC_BITS(L), .WEIGHT(plsa_pkg::WEIGHT_B)) u_lane_b (
		.clk(clk), .load(accept), .code(blue), .prod_s1(prod_b)
	);
	plsa_lane #(.LIN_FRAC_BITS(L), .WEIGHT(plsa_pkg::WEIGHT_G)) u_lane_g (
		.clk(clk), .load(accept), .code(green), .prod_s1(prod_g)
	);
	plsa_lane #(.LIN_FRAC_BITS(L), .WEIGHT(plsa_pkg::WEIGHT_R)) u_lane_r (
		.clk(clk), .load(accept), .code(red), .prod_s1(prod_r)
	);

	assign lum_num = NUM_W'(s_q) * NUM_W'(plsa_pkg::LUM_SCALE);

	// The rounding bias is a whole multiple of the fraction unit, so it is added after the shift.
	assign lum_prod = plsa_pkg::LUM_P_W'(lum_m_q) * plsa_pkg::LUM_P_W'(plsa_pkg::LUM_RECIP);
	assign lum_quo = lum_prod[plsa_pkg::LUM_P_W-1:plsa_pkg::LUM_RECIP_SH];

	plsa_div #(.NUM_W(plsa_pkg::SUM_W), .DEN_W(plsa_pkg::CNT_W), .Q_W(plsa_pkg::SUM_W)) u_avg_div (
		.clk(clk), .arst_n(arst_n), .start(avg_start), .num(sum_q), .den(cnt_q),
		.done_q(avg_done), .quo_q(avg_quo)
	);

	// Geometry of the pixel being accepted.
	always_comb begin
		wd = GW'(fw_q);
		if (fw_q == '0) begin
			wd = GW'(1);
		end else if (GW'(fw_q) > GW'(MAX_WIDTH)) begin
			wd = GW'(MAX_WIDTH);
		end
		ht = GW'(fh_q);
		if (fh_q == '0) begin
			ht = GW'(1);
		end else if (GW'(fh_q) > GW'(MAX_HEIGHT)) begin
			ht = GW'(MAX_HEIGHT);
		end
		x = start_of_frame ? '0 : GW'(col_q);
		y = start_of_frame ? '0 : GW'(row_q);
		xmin = GW'(bl_q) - GW'(mc_q);
		if (xmin < 0) begin
			xmin = '0;
		end
		xmax = GW'(br_q) + GW'(mc_q);
		if (xmax > wd) begin
			xmax = wd;
		end
		ymin = GW'(bt_q) - GW'(mr_q);
		if (ymin < 0) begin
			ymin = '0;
		end
		ymax = GW'(bb_q) + GW'(mr_q);
		if (ymax > ht) begin
			ymax = ht;
		end
		in_box = x > GW'(bl_q) && x < GW'(br_q) && y > GW'(bt_q) && y < GW'(bb_q);
		in_region = x >= xmin && x < xmax && y >= ymin && y < ymax && !in_box;
		col_wrap = x + GW'(1) >= wd;
		row_wrap = y + GW'(1) >= ht;
		is_last = col_wrap && row_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		avg_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			plsa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = plsa_pkg::ST_SUM;
				end
			end
			plsa_pkg::ST_SUM: state_d = plsa_pkg::ST_NUM;
			plsa_pkg::ST_NUM: state_d = plsa_pkg::ST_LDIV;
			plsa_pkg::ST_LDIV: state_d = plsa_pkg::ST_ACC;
			plsa_pkg::ST_ACC: state_d = last_q ? plsa_pkg::ST_AVG : plsa_pkg::ST_DONE;
			plsa_pkg::ST_AVG: begin
				if (cnt_q == '0) begin
					state_d = plsa_pkg::ST_DONE;
				end else begin
					avg_start = 1'b1;
					state_d = plsa_pkg::ST_ADIV;
				end
			end
			plsa_pkg::ST_ADIV: begin
				if (avg_done) begin
					state_d = plsa_pkg::ST_DONE;
				end
			end
			plsa_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = plsa_pkg::ST_IDLE;
				end
			end
			default: state_d = plsa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= CW'(640);
			fh_q <= CW'(480);
			bl_q <= '0;
			bt_q <= '0;
			br_q <= '0;
			bb_q <= '0;
			mc_q <= '0;
			mr_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				plsa_pkg::REG_FRAME_WIDTH:  fw_q <= pwdata[CW-1:0];
				plsa_pkg::REG_FRAME_HEIGHT: fh_q <= pwdata[CW-1:0];
				plsa_pkg::REG_BOX_LEFT:     bl_q <= pwdata[CW-1:0];
				plsa_pkg::REG_BOX_TOP:      bt_q <= pwdata[CW-1:0];
				plsa_pkg::REG_BOX_RIGHT:    br_q <= pwdata[CW-1:0];
				plsa_pkg::REG_BOX_BOTTOM:   bb_q <= pwdata[CW-1:0];
				plsa_pkg::REG_MARGIN_COLS:  mc_q <= pwdata[MW-1:0];
				plsa_pkg::REG_MARGIN_ROWS:  mr_q <= pwdata[MW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			plsa_pkg::REG_FRAME_WIDTH:  prdata = plsa_pkg::DATA_W'(fw_q);
			plsa_pkg::REG_FRAME_HEIGHT: prdata = plsa_pkg::DATA_W'(fh_q);
			plsa_pkg::REG_BOX_LEFT:     prdata = plsa_pkg::DATA_W'(bl_q);
			plsa_pkg::REG_BOX_TOP:      prdata = plsa_pkg::DATA_W'(bt_q);
			plsa_pkg::REG_BOX_RIGHT:    prdata = plsa_pkg::DATA_W'(br_q);
			plsa_pkg::REG_BOX_BOTTOM:   prdata = plsa_pkg::DATA_W'(bb_q);
			plsa_pkg::REG_MARGIN_COLS:  prdata = plsa_pkg::DATA_W'(mc_q);
			plsa_pkg::REG_MARGIN_ROWS:  prdata = plsa_pkg::DATA_W'(mr_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			region_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				region_q <= in_region;
				last_q <= is_last;
				if (start_of_frame) begin
					sum_q <= '0;
					cnt_q <= '0;
				end
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : ROW_W'(y + GW'(1));
				end else begin
					col_q <= COL_W'(x + GW'(1));
					row_q <= ROW_W'(y);
				end
			end
			if (state_q == plsa_pkg::ST_ACC && region_q) begin
				sum_q <= sum_q + plsa_pkg::SUM_W'(lum_q);
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					sum_q <= '0;
					cnt_q <= '0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == plsa_pkg::ST_SUM) begin
			s_q <= prod_b + prod_g + prod_r;
		end
		if (state_q == plsa_pkg::ST_NUM) begin
			lum_m_q <= plsa_pkg::LUM_M_W'(lum_num >> L) + plsa_pkg::LUM_M_W'(plsa_pkg::LUM_HALF);
		end
		if (state_q == plsa_pkg::ST_LDIV) begin
			lum_q <= lum_quo[8] ? 8'hFF : lum_quo[7:0];
		end
		if (avg_done) begin
			avg_q <= avg_quo[7:0];
		end
		if (out_load) begin
			luminance <= lum_q;
			average_valid <= last_q;
			region_empty <= last_q && (cnt_q == '0);
			surround_average <= (last_q && cnt_q != '0) ? avg_q : 8'd0;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == plsa_pkg::ST_SUM)
		else $error("accepted item did not start the lanes");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plsa_pkg::ST_LDIV |=> state_q == plsa_pkg::ST_ACC)
		else $error("luminance multiply did not hand over to the accumulator");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region_empty |-> average_valid && surround_average == 8'd0)
		else $error("empty region flagged on a non-final item");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(luminance))
		else $error("stalled result changed");

endmodule

`default_nettype wire

@@ rtl/core/plsa_lane.sv @@
`default_nettype none

module plsa_lane #(
	parameter int LIN_FRAC_BITS = 16,
	parameter int WEIGHT = 722
) (
	input  wire logic                          clk,
	input  wire logic                          load,
	input  wire logic [7:0]                    code,
	output logic      [LIN_FRAC_BITS+13:0]     prod_s1
);

	localparam int PROD_W = LIN_FRAC_BITS + 14;

	logic [LIN_FRAC_BITS-1:0] rom [256];

	for (genvar i = 0; i < 256; i++) begin : g_rom
		localparam logic [31:0] LV = plsa_pkg::lin_value(i, LIN_FRAC_BITS);
		assign rom[i] = LV[LIN_FRAC_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PROD_W'(rom[code]) * PROD_W'(WEIGHT);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/plsa_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit a cycle. The caller keeps num below
// den shifted left by Q_W.
module plsa_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 25,
	parameter int Q_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done_q,
	output logic      [Q_W-1:0]   quo_q
);

	localparam int D_W = DEN_W + Q_W - 1;
	localparam int C_W = (NUM_W > D_W) ? NUM_W : D_W;
	localparam int N_W = $clog2(Q_W + 1);

	logic [NUM_W-1:0] rem_q;
	logic [D_W-1:0]   dsh_q;
	logic [N_W-1:0]   cnt_q;
	logic             busy_q;
	logic             fits;

	assign fits = C_W'(rem_q) >= C_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= N_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == N_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= D_W'(den) << (Q_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= NUM_W'(C_W'(rem_q) - C_W'(dsh_q));
			end
			quo_q <= {quo_q[Q_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb_pixel_luminance_surround_average.sv @@
`timescale 1ns / 100ps

module tb_pixel_luminance_surround_average;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0] lum;
		logic       avg_valid;
		logic [7:0] avg;
		logic       empty;
	} pix_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic start_of_frame;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] luminance;
	logic average_valid;
	logic [7:0] surround_average;
	logic region_empty;
	logic psel;
	logic penable;
	logic pwrite;
	logic [plsa_pkg::ADDR_W-1:0] paddr;
	logic [plsa_pkg::DATA_W-1:0] pwdata;
	logic [plsa_pkg::DATA_W-1:0] prdata;
	logic pready;

	pixel_luminance_surround_average i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.blue(blue), .green(green), .red(red), .start_of_frame(start_of_frame),
		.out_valid(out_valid), .out_ready(out_ready),
		.luminance(luminance), .average_valid(average_valid),
		.surround_average(surround_average), .region_empty(region_empty),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Mirror of the block's registers and frame state.
	logic [12:0] cfg_width, cfg_height, cfg_left, cfg_top, cfg_right, cfg_bottom;
	logic [11:0] cfg_mcols, cfg_mrows;
	logic [11:0] col_pos, row_pos;
	logic [31:0] ring_sum;
	logic [24:0] ring_count;
	logic [15:0] srgb_to_linear [256];

	pix_result_t pending_results[$];
	int errors = 0;
	int in_idle_pct;
	int out_idle_pct;
	int idle_count = 0;
	int hold_left = 0;
	logic hold_start;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned q30_pow5(longint unsigned y);
		longint unsigned acc;
		acc = y;
		repeat (4) acc = (acc * y) >> 30;
		return acc;
	endfunction

	function automatic logic [15:0] linearize(int unsigned code);
		longint unsigned one, val, t, t2, lo, hi, mid;
		one = 64'd1 << 30;
		if (code <= 10) begin
			val = (longint'(code) * 100 * 65536 + 164730) / 329460;
		end else begin
			t = (longint'(1000 * code + 14025) * one + 134512) / 269025;
			if (t > one) begin
				t = one;
			end
			t2 = (t * t + (one >> 1)) >> 30;
			lo = 0;
			hi = one;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				if (q30_pow5(mid) <= t2) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
			val = (((t2 * lo) >> 30) + (64'd1 << 13)) >> 14;
		end
		if (val > 65535) begin
			val = 65535;
		end
		return val[15:0];
	endfunction

	function automatic pix_result_t predict_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
			logic sof);
		pix_result_t res;
		longint unsigned s, lum;
		int w, h, x, y, xmin, xmax, ymin, ymax;
		logic interior;
		if (sof) begin
			col_pos = '0;
			row_pos = '0;
			ring_sum = '0;
			ring_count = '0;
		end
		w = (cfg_width == 0) ? 1 : (cfg_width > 4096) ? 4096 : int'(cfg_width);
		h = (cfg_height == 0) ? 1 : (cfg_height > 4096) ? 4096 : int'(cfg_height);
		s = 722 * longint'(srgb_to_linear[b]) + 7152 * longint'(srgb_to_linear[g])
			+ 2126 * longint'(srgb_to_linear[r]);
		lum = (255 * s + 5000 * 65536) / (10000 * 65536);
		if (lum > 255) begin
			lum = 255;
		end
		x = int'(col_pos);
		y = int'(row_pos);
		xmin = int'(cfg_left) - int'(cfg_mcols);
		if (xmin < 0) xmin = 0;
		xmax = int'(cfg_right) + int'(cfg_mcols);
		if (xmax > w) xmax = w;
		ymin = int'(cfg_top) - int'(cfg_mrows);
		if (ymin < 0) ymin = 0;
		ymax = int'(cfg_bottom) + int'(cfg_mrows);
		if (ymax > h) ymax = h;
		interior = x > int'(cfg_left) && x < int'(cfg_right) && y > int'(cfg_top)
			&& y < int'(cfg_bottom);
		if (x >= xmin && x < xmax && y >= ymin && y < ymax && !interior) begin
			ring_sum = ring_sum + 32'(lum);
			ring_count = ring_count + 1;
		end
		res = '0;
		res.lum = lum[7:0];
		if (x + 1 >= w) begin
			col_pos = '0;
			if (y + 1 >= h) begin
				res.avg_valid = 1'b1;
				if (ring_count == 0) begin
					res.empty = 1'b1;
				end else begin
					res.avg = 8'(ring_sum / 32'(ring_count));
				end
				row_pos = '0;
				ring_sum = '0;
				ring_count = '0;
			end else begin
				row_pos = row_pos + 1;
			end
		end else begin
			col_pos = col_pos + 1;
		end
		return res;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		pix_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (luminance !== want.lum) report_mismatch("luminance", luminance, want.lum);
				if (average_valid !== want.avg_valid)
					report_mismatch("average_valid", average_valid, want.avg_valid);
				if (surround_average !== want.avg)
					report_mismatch("surround_average", surround_average, want.avg);
				if (region_empty !== want.empty)
					report_mismatch("region_empty", region_empty, want.empty);
			end
		end
		out_ready <= (hold_left != 0 || hold_start) ? 1'b0
			: ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		if (hold_start && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			idle_count <= 0;
		end else if (idle_count >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	task automatic write_reg(logic [2:0] index, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= plsa_pkg::ADDR_W'({index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (index)
			plsa_pkg::REG_FRAME_WIDTH:  cfg_width = value[12:0];
			plsa_pkg::REG_FRAME_HEIGHT: cfg_height = value[12:0];
			plsa_pkg::REG_BOX_LEFT:     cfg_left = value[12:0];
			plsa_pkg::REG_BOX_TOP:      cfg_top = value[12:0];
			plsa_pkg::REG_BOX_RIGHT:    cfg_right = value[12:0];
			plsa_pkg::REG_BOX_BOTTOM:   cfg_bottom = value[12:0];
			plsa_pkg::REG_MARGIN_COLS:  cfg_mcols = value[11:0];
			plsa_pkg::REG_MARGIN_ROWS:  cfg_mrows = value[11:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Upper bits of the frame size and margin writes are random so the register masking is exercised.
	task automatic set_geometry(int w, int h, int l, int t, int r, int b, int mc, int mr);
		wait_idle();
		write_reg(plsa_pkg::REG_FRAME_WIDTH,
			{3'($urandom_range(7)), 29'(w)} & 32'hE000_1FFF);
		write_reg(plsa_pkg::REG_FRAME_HEIGHT,
			{3'($urandom_range(7)), 29'(h)} & 32'hE000_1FFF);
		write_reg(plsa_pkg::REG_BOX_LEFT, 32'(l));
		write_reg(plsa_pkg::REG_BOX_TOP, 32'(t));
		write_reg(plsa_pkg::REG_BOX_RIGHT, 32'(r));
		write_reg(plsa_pkg::REG_BOX_BOTTOM, 32'(b));
		write_reg(plsa_pkg::REG_MARGIN_COLS,
			{4'($urandom_range(15)), 28'(mc)} & 32'hF000_0FFF);
		write_reg(plsa_pkg::REG_MARGIN_ROWS,
			{4'($urandom_range(15)), 28'(mr)} & 32'hF000_0FFF);
	endtask

	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic sof);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		start_of_frame <= sof;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_pixel(b, g, r, sof));
	endtask

	task automatic send_frame(int n_pixels);
		for (int i = 0; i < n_pixels; i++) begin
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
		end
	endtask

	task automatic test_directed();
		in_idle_pct = 0;
		out_idle_pct = 0;
		set_geometry(4, 3, 1, 0, 3, 2, 1, 1);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd10, 8'd10, 8'd10, 1'b0);
		send_pixel(8'd11, 8'd11, 8'd11, 1'b0);
		send_pixel(8'd1, 8'd128, 8'd254, 1'b0);
		send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		// Zero width and height act as one pixel, so every pixel ends a frame.
		set_geometry(0, 0, 0, 0, 1, 1, 0, 0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd37, 8'd90, 8'd3, 1'b1);
		// The ring is empty when the box has no width and no margin.
		set_geometry(2, 2, 0, 0, 0, 0, 0, 0);
		send_frame(4);
		// Oversized width clamps to the maximum; even the largest margins leave row 0 and column 0 outside the ring.
		set_geometry(8191, 4096, 4096, 4096, 4096, 4096, 4095, 4095);
		send_frame(5);
		// A start of frame in the middle of a frame restarts it.
		set_geometry(3, 2, 0, 0, 1, 1, 2, 2);
		send_frame(3);
		send_frame(6);
	endtask

	task automatic test_random(int n_items, int sender_idle, int receiver_idle);
		int sent;
		int w, h, frame_len;
		in_idle_pct = sender_idle;
		out_idle_pct = receiver_idle;
		sent = 0;
		while (sent < n_items) begin
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			if ($urandom_range(9) == 0) begin
				set_geometry($urandom_range(1) ? 0 : 8191, $urandom_range(1, 4),
					$urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
					$urandom_range(8191), $urandom_range(4095), $urandom_range(4095));
			end else begin
				set_geometry(w, h, $urandom_range(9), $urandom_range(7),
					$urandom_range(10), $urandom_range(8), $urandom_range(4),
					$urandom_range(3));
			end
			repeat ($urandom_range(2, 5)) begin
				frame_len = int'(cfg_width == 0 ? 1 : cfg_width > 16 ? 16 : cfg_width)
					* int'(cfg_height == 0 ? 1 : cfg_height > 6 ? 6 : cfg_height);
				// Mostly whole frames; some are cut short or run on.
				case ($urandom_range(9))
					0: frame_len = $urandom_range(1, frame_len);
					1: frame_len = frame_len + $urandom_range(1, 5);
					default: ;
				endcase
				for (int i = 0; i < frame_len; i++) begin
					send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
						i == 0 || $urandom_range(49) == 0);
				end
				sent += frame_len;
			end
		end
	endtask

	task automatic test_backpressure();
		in_idle_pct = 0;
		out_idle_pct = 0;
		set_geometry(5, 4, 1, 1, 3, 3, 1, 1);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		send_frame(20);
		send_frame(20);
	endtask

	initial begin
		for (int c = 0; c < 256; c++) begin
			srgb_to_linear[c] = linearize(c);
		end
		hold_start = 1'b0;
		in_idle_pct = 0;
		out_idle_pct = 0;
		cfg_width = 13'd640;
		cfg_height = 13'd480;
		cfg_left = '0;
		cfg_top = '0;
		cfg_right = '0;
		cfg_bottom = '0;
		cfg_mcols = '0;
		cfg_mrows = '0;
		col_pos = '0;
		row_pos = '0;
		ring_sum = '0;
		ring_count = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		blue = '0;
		green = '0;
		red = '0;
		start_of_frame = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500, 33, 69);
		test_random(500, 69, 33);
		test_random(500, 0, 0);
		test_backpressure();
		wait_idle();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/plsa_pkg.sv
rtl/core/plsa_lane.sv
rtl/core/plsa_div.sv
rtl/core/pixel_luminance_surround_average.sv
tb/sv/tb_pixel_luminance_surround_average.sv
